// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of the mixer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define OMD_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define OMD_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- hdl/omd_pkg.sv -----
// Types, constants and helper functions of the omni drive motor mixer.
`timescale 1ns / 1ps
`default_nettype none
package omd_pkg;

	localparam int COSINE_TABLE_DEPTH = 360;
	localparam int DEG_PER_TURN       = 360;
	localparam int QUARTER_TURN_DEG   = 90;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1073741824;

	// Series factors of the cosine and sine terms, one per term after the first.
	localparam longint unsigned COS_TERM_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};
	localparam longint unsigned SIN_TERM_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

	localparam int FIELD_W = 9;
	localparam int GAIN_W  = 15;
	localparam int COS_W   = 16;
	localparam int NUM_WHEELS = 3;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_ANGLE_A = 3'd0;
	localparam logic [2:0] REG_ANGLE_B = 3'd1;
	localparam logic [2:0] REG_ANGLE_C = 3'd2;
	localparam logic [2:0] REG_GAIN_A  = 3'd3;
	localparam logic [2:0] REG_GAIN_B  = 3'd4;
	localparam logic [2:0] REG_GAIN_C  = 3'd5;

	localparam logic [8:0]  ANGLE_A_RST = 9'd0;
	localparam logic [8:0]  ANGLE_B_RST = 9'd120;
	localparam logic [8:0]  ANGLE_C_RST = 9'd240;
	localparam logic [14:0] GAIN_RST    = 15'd16384;

	localparam int DIV_N_W = 50;
	localparam int DIV_D_W = 41;
	localparam int DIV_Q_W = 9;

	typedef logic signed [COS_W-1:0] cos_tab_t [DEG_PER_TURN];

	typedef struct packed {
		logic [NUM_WHEELS-1:0][FIELD_W-1:0] angle;
		logic [NUM_WHEELS-1:0][GAIN_W-1:0]  gain;
	} cfg_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_Q_W-1:0] quotient;
	} div_rsp_t;

	function automatic longint clamp_q30_to_q15(input longint v);
		longint r;
		r = v;
		if (r < 0) r = 0;
		if (r > longint'(ONE_Q30)) r = longint'(ONE_Q30);
		r = (r + 16384) >>> 15;
		if (r > 32767) r = 32767;
		return r;
	endfunction

	// Cosine table indexed by whole degrees, evaluated during elaboration.
	function automatic cos_tab_t build_cos_tab();
		cos_tab_t tab;
		longint unsigned t, q, m, x, x2, ct, st;
		longint c, s, v;
		for (int d = 0; d < DEG_PER_TURN; d++) begin
			t  = longint'(d) * COSINE_TABLE_DEPTH / DEG_PER_TURN;
			t  = t % COSINE_TABLE_DEPTH;
			q  = (4 * t) / COSINE_TABLE_DEPTH;
			m  = (4 * t) % COSINE_TABLE_DEPTH;
			x  = m * HALF_PI_Q30 / COSINE_TABLE_DEPTH;
			x2 = (x * x) >> 30;
			ct = ONE_Q30;
			st = x;
			c  = longint'(ct);
			s  = longint'(st);
			for (int k = 1; k < 8; k++) begin
				ct = ((ct * x2) >> 30) / COS_TERM_DIV[k-1];
				st = ((st * x2) >> 30) / SIN_TERM_DIV[k-1];
				if ((k % 2) == 1) begin
					c = c - longint'(ct);
					s = s - longint'(st);
				end else begin
					c = c + longint'(ct);
					s = s + longint'(st);
				end
			end
			c = clamp_q30_to_q15(c);
			s = clamp_q30_to_q15(s);
			unique case (q[1:0])
				2'd0: v = c;
				2'd1: v = -s;
				2'd2: v = -c;
				default: v = s;
			endcase
			tab[d] = COS_W'(v);
		end
		return tab;
	endfunction

	// Angle between a wheel's mounting direction, turned a quarter, and the heading.
	function automatic logic [8:0] deg_wrap(input logic [8:0] ang, input logic [8:0] hd);
		logic [8:0] a;
		logic [8:0] h;
		logic signed [10:0] d;
		a = (ang >= 9'(DEG_PER_TURN)) ? ang - 9'(DEG_PER_TURN) : ang;
		h = (hd >= 9'(DEG_PER_TURN)) ? hd - 9'(DEG_PER_TURN) : hd;
		d = $signed({2'b00, a}) + 11'(QUARTER_TURN_DEG) - $signed({2'b00, h});
		if (d < 0) begin
			d = d + 11'(DEG_PER_TURN);
		end else if (d >= 11'(DEG_PER_TURN)) begin
			d = d - 11'(DEG_PER_TURN);
		end
		return d[8:0];
	endfunction

	// Negates a drive value and clamps it to the symmetric nine-bit range.
	function automatic logic [8:0] drive_sat(input logic signed [9:0] v);
		logic signed [10:0] n;
		n = -$signed({v[9], v});
		if (n > 11'sd255) begin
			return 9'd255;
		end else if (n < -11'sd255) begin
			return 9'h101;
		end
		return n[8:0];
	endfunction

endpackage
`default_nettype wire

// ----- hdl/omd_cmd_if.sv -----
// Request channel carrying one motion command into the mixer.
`timescale 1ns / 1ps
`default_nettype none
interface omd_cmd_if;
	logic              valid;
	logic              ready;
	logic [8:0]        heading_deg;
	logic signed [8:0] turn_rate;
	logic signed [8:0] travel_speed;

	modport source(output valid, output heading_deg, output turn_rate, output travel_speed,
		input ready);
	modport sink(input valid, input heading_deg, input turn_rate, input travel_speed,
		output ready);
endinterface
`default_nettype wire

// ----- hdl/omd_drive_if.sv -----
// Result channel carrying the three wheel drive values out of the mixer.
`timescale 1ns / 1ps
`default_nettype none
interface omd_drive_if;
	logic              valid;
	logic              ready;
	logic signed [8:0] drive_wheel_a;
	logic signed [8:0] drive_wheel_b;
	logic signed [8:0] drive_wheel_c;

	modport source(output valid, output drive_wheel_a, output drive_wheel_b,
		output drive_wheel_c, input ready);
	modport sink(input valid, input drive_wheel_a, input drive_wheel_b,
		input drive_wheel_c, output ready);
endinterface
`default_nettype wire

// ----- hdl/omd_cfg.sv -----
// APB-style register file holding the wheel angles and gains.
`timescale 1ns / 1ps
`default_nettype none
module omd_cfg
	import omd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output cfg_t             cfg
);
	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle[0] <= ANGLE_A_RST;
			cfg_q.angle[1] <= ANGLE_B_RST;
			cfg_q.angle[2] <= ANGLE_C_RST;
			cfg_q.gain[0]  <= GAIN_RST;
			cfg_q.gain[1]  <= GAIN_RST;
			cfg_q.gain[2]  <= GAIN_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_ANGLE_A: cfg_q.angle[0] <= pwdata[8:0];
				REG_ANGLE_B: cfg_q.angle[1] <= pwdata[8:0];
				REG_ANGLE_C: cfg_q.angle[2] <= pwdata[8:0];
				REG_GAIN_A:  cfg_q.gain[0]  <= pwdata[14:0];
				REG_GAIN_B:  cfg_q.gain[1]  <= pwdata[14:0];
				REG_GAIN_C:  cfg_q.gain[2]  <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ANGLE_A: prdata = {23'd0, cfg_q.angle[0]};
			REG_ANGLE_B: prdata = {23'd0, cfg_q.angle[1]};
			REG_ANGLE_C: prdata = {23'd0, cfg_q.angle[2]};
			REG_GAIN_A:  prdata = {17'd0, cfg_q.gain[0]};
			REG_GAIN_B:  prdata = {17'd0, cfg_q.gain[1]};
			REG_GAIN_C:  prdata = {17'd0, cfg_q.gain[2]};
			default:     prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

// ----- hdl/omd_cos_rom.sv -----
// Cosine lookup in Q1.15, one entry per whole degree, registered read.
`timescale 1ns / 1ps
`default_nettype none
module omd_cos_rom
	import omd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic [8:0]  addr,
	output logic signed [COS_W-1:0] rd_data
);
	localparam cos_tab_t COS_TAB = build_cos_tab();

	logic signed [COS_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		rd_q <= COS_TAB[addr];
	end

	assign rd_data = rd_q;
endmodule
`default_nettype wire

// ----- hdl/omd_div.sv -----
// Restoring divider yielding a nine-bit quotient, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module omd_div
	import omd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  div_req_t  req,
	output div_rsp_t  rsp
);
	logic [DIV_N_W-1:0] rem_q;
	logic [DIV_N_W-1:0] dsh_q;
	logic [DIV_Q_W-1:0] quo_q;
	logic [3:0]         cnt_q;
	logic               busy_q;
	logic               done_q;
	logic               fits;

	assign fits = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 4'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(DIV_Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// The quotient never exceeds nine bits, so the divisor starts eight places up.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			dsh_q <= {1'b0, req.divisor, 8'd0};
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[DIV_Q_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule
`default_nettype wire

// ----- hdl/omni_drive_motor_mixer_core.sv -----
// Top level of the three-wheel omni drive mixer: sequencer, shared multiplier, sub-units.
//
//  Port     Direction  Handshake        Contents
//  cmd      in         valid / ready    heading_deg, turn_rate, travel_speed
//  drv      out        valid / ready    drive_wheel_a, drive_wheel_b, drive_wheel_c
//  APB      in / out   psel / penable   wheel angles and gains, always ready
//
// A repeated command is dropped in its accept cycle; a zero-speed command goes straight to the
// final step. Otherwise a command takes three ROM reads, three passes through the multiply
// steps on the one shared multiplier and up to three nine-step serial divisions, which dominate.
// cmd.ready is high only while the sequencer is idle; a finished result waits in the output
// register, and the sequencer holds its last step until that register is free.
// Reset clears the control state and the last-command registers and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module omni_drive_motor_mixer_core
	import omd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	omd_cmd_if.sink          cmd,
	omd_drive_if.source      drv,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RADDR = 4'd1;
	localparam logic [3:0] ST_RDATA = 4'd2;
	localparam logic [3:0] ST_M1    = 4'd3;
	localparam logic [3:0] ST_M2    = 4'd4;
	localparam logic [3:0] ST_M3    = 4'd5;
	localparam logic [3:0] ST_M4    = 4'd6;
	localparam logic [3:0] ST_M5    = 4'd7;
	localparam logic [3:0] ST_D1    = 4'd8;
	localparam logic [3:0] ST_D2    = 4'd9;
	localparam logic [3:0] ST_D3    = 4'd10;
	localparam logic [3:0] ST_FIN   = 4'd11;

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [3:0] state_q;
	logic [1:0] k_q;

	logic [8:0]        last_heading_q;
	logic [8:0]        last_turn_q;
	logic [8:0]        last_speed_q;
	logic [8:0]        heading_q;
	logic signed [8:0] turn_q;
	logic signed [8:0] speed_q;

	logic signed [COS_W-1:0] r_q [NUM_WHEELS];
	logic [14:0]             hmax_q;
	logic signed [25:0]      sum_q;
	logic signed [40:0]      t_q [NUM_WHEELS];
	logic [40:0]             tmax_q;
	logic                    neg_q;
	logic [8:0]              res_q [NUM_WHEELS];

	logic signed [40:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [57:0] mul_q;

	logic                    drv_valid_q;
	logic [8:0]              drv_a_q;
	logic [8:0]              drv_b_q;
	logic [8:0]              drv_c_q;

	logic                    accept;
	logic                    repeat_cmd;
	logic [8:0]              rom_addr;
	logic signed [COS_W-1:0] rom_data;
	logic [COS_W-1:0]        rom_mag;
	logic [40:0]             t_new;
	logic [40:0]             t_mag;
	logic [49:0]             prod_mag;
	logic signed [9:0]       div_val;
	logic                    out_free;

	omd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	omd_cos_rom u_rom (
		.clk     (clk),
		.addr    (rom_addr),
		.rd_data (rom_data)
	);

	omd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign cmd.ready  = (state_q == ST_IDLE);
	assign accept     = cmd.valid && cmd.ready;
	assign repeat_cmd = (cmd.heading_deg == last_heading_q) &&
		(cmd.turn_rate == last_turn_q) && (cmd.travel_speed == last_speed_q);
	assign out_free   = !drv_valid_q || drv.ready;

	assign rom_addr = deg_wrap(cfg.angle[k_q], heading_q);
	assign rom_mag  = rom_data[COS_W-1] ? COS_W'(-rom_data) : COS_W'(rom_data);
	assign t_new    = mul_q[40:0];
	assign t_mag    = t_new[40] ? 41'(-$signed(t_new)) : t_new;
	assign prod_mag = mul_q[49] ? 50'(-$signed(mul_q[49:0])) : mul_q[49:0];
	assign div_val  = neg_q ? -$signed({1'b0, div_rsp.quotient})
		: $signed({1'b0, div_rsp.quotient});

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (state_q)
			ST_M1: begin
				mul_a = 41'(r_q[k_q]);
				mul_b = 17'(speed_q);
			end
			ST_M2: begin
				mul_a = 41'(turn_q);
				mul_b = $signed({2'b00, hmax_q});
			end
			ST_M4: begin
				mul_a = 41'(sum_q);
				mul_b = $signed({2'b00, cfg.gain[k_q]});
			end
			ST_D1: begin
				mul_a = t_q[k_q];
				mul_b = 17'(speed_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	assign div_req.start    = (state_q == ST_D2) && (tmax_q != '0);
	assign div_req.dividend = prod_mag;
	assign div_req.divisor  = tmax_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			k_q            <= '0;
			last_heading_q <= '0;
			last_turn_q    <= '0;
			last_speed_q   <= '0;
			drv_valid_q    <= 1'b0;
		end else begin
			// In the final step the output register is refilled below instead.
			if (drv_valid_q && drv.ready && (state_q != ST_FIN)) begin
				drv_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !repeat_cmd) begin
						last_heading_q <= cmd.heading_deg;
						last_turn_q    <= cmd.turn_rate;
						last_speed_q   <= cmd.travel_speed;
						k_q            <= '0;
						state_q        <= (cmd.travel_speed == '0) ? ST_FIN : ST_RADDR;
					end
				end
				ST_RADDR: state_q <= ST_RDATA;
				ST_RDATA: begin
					if (k_q == 2'd2) begin
						k_q     <= '0;
						state_q <= ST_M1;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_RADDR;
					end
				end
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_M4;
				ST_M4: state_q <= ST_M5;
				ST_M5: begin
					if (k_q == 2'd2) begin
						k_q     <= '0;
						state_q <= ST_D1;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_M1;
					end
				end
				ST_D1: state_q <= ST_D2;
				ST_D2: begin
					// With every wheel term zero the division is skipped and the output is zero.
					if (tmax_q == '0) begin
						if (k_q == 2'd2) begin
							state_q <= ST_FIN;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= ST_D1;
						end
					end else begin
						state_q <= ST_D3;
					end
				end
				ST_D3: begin
					if (div_rsp.done) begin
						if (k_q == 2'd2) begin
							state_q <= ST_FIN;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= ST_D1;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						drv_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, loaded under the sequencer's control.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					heading_q <= cmd.heading_deg;
					turn_q    <= cmd.turn_rate;
					speed_q   <= cmd.travel_speed;
					hmax_q    <= '0;
					tmax_q    <= '0;
					for (int i = 0; i < NUM_WHEELS; i++) begin
						res_q[i] <= drive_sat(10'(cmd.turn_rate));
					end
				end
			end
			ST_RDATA: begin
				r_q[k_q] <= rom_data;
				if (rom_mag[14:0] > hmax_q) begin
					hmax_q <= rom_mag[14:0];
				end
			end
			ST_M2: sum_q <= mul_q[25:0];
			ST_M3: sum_q <= sum_q + $signed(mul_q[25:0]);
			ST_M5: begin
				t_q[k_q] <= $signed(t_new);
				if (t_mag > tmax_q) begin
					tmax_q <= t_mag;
				end
			end
			ST_D2: begin
				neg_q <= mul_q[57];
				if (tmax_q == '0) begin
					res_q[k_q] <= '0;
				end
			end
			ST_D3: begin
				if (div_rsp.done) begin
					res_q[k_q] <= drive_sat(div_val);
				end
			end
			ST_FIN: begin
				if (out_free) begin
					drv_a_q <= res_q[0];
					drv_b_q <= res_q[1];
					drv_c_q <= res_q[2];
				end
			end
			default: ;
		endcase
	end

	assign drv.valid         = drv_valid_q;
	assign drv.drive_wheel_a = drv_a_q;
	assign drv.drive_wheel_b = drv_b_q;
	assign drv.drive_wheel_c = drv_c_q;
endmodule
`default_nettype wire

// ----- hdl/omd_chk.sv -----
// Port-level checker for the mixer top level, with its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module omd_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cmd_valid,
	input wire logic       cmd_ready,
	input wire logic       drv_valid,
	input wire logic       drv_ready,
	input wire logic [8:0] drive_wheel_a,
	input wire logic [8:0] drive_wheel_b,
	input wire logic [8:0] drive_wheel_c
);
	// Even the quickest request needs one more step, so no result is issued straight after it.
	`OMD_ASSERT_NXT(a_no_instant_result, cmd_valid && cmd_ready, !$rose(drv_valid), "result issued in the cycle after a request")

	// A result is issued as the sequencer returns to idle, so ready is high with it.
	`OMD_ASSERT_IMP(a_idle_with_result, $rose(drv_valid), cmd_ready, "sequencer busy when a result was issued")

	// A stalled result keeps its values.
	`OMD_ASSERT_NXT(a_drv_hold, drv_valid && !drv_ready, drv_valid && $stable(drive_wheel_a) && $stable(drive_wheel_b) && $stable(drive_wheel_c), "stalled result changed")

	// Saturation keeps every drive value off the most negative code.
	`OMD_ASSERT_IMP(a_drv_sat, drv_valid, drive_wheel_a != 9'h100 && drive_wheel_b != 9'h100 && drive_wheel_c != 9'h100, "drive value outside the saturated range")
endmodule

bind omni_drive_motor_mixer_core omd_chk u_omd_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.drv_valid     (drv.valid),
	.drv_ready     (drv.ready),
	.drive_wheel_a (drv.drive_wheel_a),
	.drive_wheel_b (drv.drive_wheel_b),
	.drive_wheel_c (drv.drive_wheel_c)
);
`default_nettype wire

// ----- dv/omni_drive_motor_mixer_core_tb.sv -----
// Self-checking testbench of the three-wheel omni drive mixer.
`timescale 1ns / 1ps
`default_nettype none
module omni_drive_motor_mixer_core_tb;
	import omd_pkg::*;

	typedef struct {
		logic signed [8:0] wa;
		logic signed [8:0] wb;
		logic signed [8:0] wc;
	} drive_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	omd_cmd_if cmd();
	omd_drive_if drv();

	omni_drive_motor_mixer_core uut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd.sink), .drv(drv.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// Predictor state: configuration and the last command that produced drive values.
	logic [8:0] mount_deg [3];
	logic [14:0] wheel_gain [3];
	logic [8:0] prev_heading, prev_turn, prev_speed;
	drive_set_t drive_expected [$];
	int unsigned fail_count = 0;
	bit hold_drive = 1'b0;
	bit random_stall = 1'b1;

	initial begin
		cmd.valid = 1'b0;
		cmd.heading_deg = '0;
		cmd.turn_rate = '0;
		cmd.travel_speed = '0;
		drv.ready = 1'b0;
	end

	function automatic longint cos_q15_of(input longint unsigned deg);
		longint unsigned t, q, m, x, x2, ct, st;
		longint c, s;
		t = (deg * COSINE_TABLE_DEPTH / 360) % COSINE_TABLE_DEPTH;
		q = (4 * t) / COSINE_TABLE_DEPTH;
		m = (4 * t) % COSINE_TABLE_DEPTH;
		x = m * 64'd1686629713 / COSINE_TABLE_DEPTH;
		x2 = (x * x) >> 30;
		ct = 64'd1073741824;
		st = x;
		c = ct;
		s = st;
		for (int k = 1; k < 8; k++) begin
			ct = ((ct * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
			st = ((st * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2) begin
				c -= ct;
				s -= st;
			end else begin
				c += ct;
				s += st;
			end
		end
		if (c < 0) c = 0;
		if (c > 1073741824) c = 1073741824;
		c = (c + 16384) >>> 15;
		if (c > 32767) c = 32767;
		if (s < 0) s = 0;
		if (s > 1073741824) s = 1073741824;
		s = (s + 16384) >>> 15;
		if (s > 32767) s = 32767;
		case (q % 4)
			0: return c;
			1: return -s;
			2: return -c;
			default: return s;
		endcase
	endfunction

	function automatic logic signed [8:0] negate_clamp(input longint v);
		longint n;
		n = -v;
		if (n > 255) n = 255;
		if (n < -255) n = -255;
		return n[8:0];
	endfunction

	// Works out the drive values of one accepted command, if it produces any.
	function automatic void mix_command(input logic [8:0] hd, input logic [8:0] tb,
		input logic [8:0] sb);
		longint turn, speed, r[3], tv[3], hmax, tmax, d;
		drive_set_t res;
		longint o[3];
		hmax = 0;
		tmax = 0;
		if (hd == prev_heading && tb == prev_turn && sb == prev_speed) return;
		prev_heading = hd;
		prev_turn = tb;
		prev_speed = sb;
		turn = longint'($signed(tb));
		speed = longint'($signed(sb));
		for (int i = 0; i < 3; i++) begin
			if (speed == 0) begin
				o[i] = turn;
			end else begin
				d = (longint'(mount_deg[i]) + 90 + 1080 - longint'(hd)) % 360;
				r[i] = cos_q15_of(d);
				if ((r[i] < 0 ? -r[i] : r[i]) > hmax) hmax = r[i] < 0 ? -r[i] : r[i];
			end
		end
		if (speed != 0) begin
			for (int i = 0; i < 3; i++) begin
				tv[i] = (r[i] * speed + turn * hmax) * longint'(wheel_gain[i]);
				if ((tv[i] < 0 ? -tv[i] : tv[i]) > tmax) tmax = tv[i] < 0 ? -tv[i] : tv[i];
			end
			for (int i = 0; i < 3; i++) o[i] = (tmax == 0) ? 0 : (tv[i] * speed) / tmax;
		end
		res.wa = negate_clamp(o[0]);
		res.wb = negate_clamp(o[1]);
		res.wc = negate_clamp(o[2]);
		drive_expected.push_back(res);
	endfunction

	// Drops the request for a random number of cycles; with no gap the next one follows at once.
	task automatic random_gap(input int unsigned bias);
		int unsigned n;
		n = ($urandom_range(0, 99) < 8) ? $urandom_range(10, 40) :
			(($urandom_range(0, 99) < bias) ? $urandom_range(1, 3) : 0);
		if (n != 0) begin
			cmd.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_command(input logic [8:0] hd, input logic [8:0] tb,
		input logic [8:0] sb);
		cmd.valid <= 1'b1;
		cmd.heading_deg <= hd;
		cmd.turn_rate <= tb;
		cmd.travel_speed <= sb;
		do @(posedge clk); while (!cmd.ready);
		mix_command(hd, tb, sb);
		if (random_stall) random_gap(30);
	endtask

	task automatic wait_drained();
		int unsigned guard;
		guard = 0;
		cmd.valid <= 1'b0;
		while (drive_expected.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (idx <= REG_ANGLE_C) mount_deg[idx] = val[8:0];
		else if (idx <= REG_GAIN_C) wheel_gain[idx - 3] = val[14:0];
	endtask

	task automatic write_setting(input logic [8:0] a0, a1, a2, input logic [14:0] g0, g1, g2);
		wait_drained();
		write_reg(REG_ANGLE_A, a0);
		write_reg(REG_ANGLE_B, a1);
		write_reg(REG_ANGLE_C, a2);
		write_reg(REG_GAIN_A, g0);
		write_reg(REG_GAIN_B, g1);
		write_reg(REG_GAIN_C, g2);
	endtask

	task automatic send_random_commands(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_command(prev_heading, prev_turn, prev_speed);
			end else begin
				send_command(($urandom_range(0, 9) == 0) ? 9'($urandom_range(360, 511)) :
					9'($urandom_range(0, 359)),
					($urandom_range(0, 15) == 0) ? 9'h100 : 9'($urandom),
					($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom));
			end
		end
	endtask

	task automatic test_directed();
		send_command(9'd0, 9'd0, 9'd0);       // identical to the reset state
		send_command(9'd0, 9'd0, 9'd255);
		send_command(9'd0, 9'd0, 9'd255);     // repeat of the previous command
		send_command(9'd90, 9'h101, 9'h101);
		send_command(9'd359, 9'd255, 9'd1);
		send_command(9'd180, 9'h100, 9'd0);   // zero speed, most negative turn
		send_command(9'd45, 9'd255, 9'd0);
		send_command(9'd511, 9'd100, 9'h100);
		send_command(9'd360, 9'h1FF, 9'h1FF);
		send_command(9'd270, 9'h155, 9'h0AA);
		send_command(9'd300, 9'h0AA, 9'h155);
	endtask

	task automatic test_settings();
		write_setting(9'd0, 9'd0, 9'd0, 15'd0, 15'd0, 15'd0);  // every divisor zero
		send_random_commands(20);
		write_setting(9'd511, 9'd359, 9'd360, 15'd32767, 15'd1, 15'd32767);
		send_random_commands(100);
		write_setting(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
			9'($urandom_range(0, 511)), 15'($urandom), 15'($urandom), 15'($urandom));
		send_random_commands(100);
	endtask

	task automatic test_backpressure();
		wait_drained();
		hold_drive = 1'b1;
		random_stall = 1'b0;
		fork
			send_random_commands(6);
			begin
				repeat (600) @(posedge clk);
				hold_drive = 1'b0;
			end
		join
		random_stall = 1'b1;
	endtask

	task automatic test_random();
		write_setting(9'd0, 9'd120, 9'd240, 15'd16384, 15'd16384, 15'd16384);
		send_random_commands(750);
	endtask

	always @(posedge clk) begin
		if (hold_drive) drv.ready <= 1'b0;
		else drv.ready <= ($urandom_range(0, 99) < 75);
	end

	// Compares each accepted result with the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && drv.valid && drv.ready) begin
			if (drive_expected.size() == 0) begin
				$error("unexpected drive result %0d %0d %0d", drv.drive_wheel_a,
					drv.drive_wheel_b, drv.drive_wheel_c);
				fail_count++;
			end else begin
				drive_set_t e;
				e = drive_expected.pop_front();
				if (drv.drive_wheel_a !== e.wa) begin
					$error("drive_wheel_a expected %0d got %0d", e.wa, drv.drive_wheel_a);
					fail_count++;
				end
				if (drv.drive_wheel_b !== e.wb) begin
					$error("drive_wheel_b expected %0d got %0d", e.wb, drv.drive_wheel_b);
					fail_count++;
				end
				if (drv.drive_wheel_c !== e.wc) begin
					$error("drive_wheel_c expected %0d got %0d", e.wc, drv.drive_wheel_c);
					fail_count++;
				end
			end
		end
	end

	initial begin
		mount_deg[0] = ANGLE_A_RST;
		mount_deg[1] = ANGLE_B_RST;
		mount_deg[2] = ANGLE_C_RST;
		for (int i = 0; i < 3; i++) wheel_gain[i] = GAIN_RST;
		prev_heading = '0;
		prev_turn = '0;
		prev_speed = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_settings();
		test_random();
		wait_drained();
		if (drive_expected.size() != 0) begin
			$error("%0d drive results never arrived", drive_expected.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#4ms;
		$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
